[hdl/ffha_pkg.sv]
package ffha_pkg;

  localparam int HEAP_BYTES   = 4096;
  localparam int HEADER_BYTES = 8;

  localparam int ADDR_W = $clog2(HEAP_BYTES);
  localparam int POS_W  = ADDR_W + 1;
  localparam int SIZE_W = ADDR_W;
  localparam int REQ_W  = 16;
  localparam int OFS_W  = 12;

  localparam logic [POS_W-1:0]  HDR_POS    = POS_W'(HEADER_BYTES);
  localparam logic [POS_W-1:0]  LAST_HDR   = POS_W'(HEAP_BYTES - HEADER_BYTES);
  localparam logic [SIZE_W-1:0] HDR_SIZE   = SIZE_W'(HEADER_BYTES);
  localparam logic [SIZE_W-1:0] FIRST_FREE = SIZE_W'(HEAP_BYTES - 2 * HEADER_BYTES);
  localparam logic [OFS_W-1:0]  HDR_OFS    = OFS_W'(HEADER_BYTES);
  localparam logic [REQ_W:0]    TWO_HDR_REQ = (REQ_W + 1)'(2 * HEADER_BYTES);
  localparam logic [REQ_W:0]    HEAP_REQ    = (REQ_W + 1)'(HEAP_BYTES);

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_FREE = 2'd1,
    KIND_USED = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_TOO_BIG = 3'd1,
    STAT_ZERO    = 3'd2,
    STAT_NO_MEM  = 3'd3,
    STAT_DOUBLE  = 3'd4,
    STAT_WRONG   = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_EV,
    ST_A_SPLIT,
    ST_R_EV,
    ST_M_RD_X,
    ST_M_EV_X,
    ST_M_EV_Y,
    ST_M_RD_Y,
    ST_M_WR_X,
    ST_DONE
  } state_t;

  typedef struct packed {
    kind_t             kind;
    logic [SIZE_W-1:0] size;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    entry_t            wdata;
  } mem_req_t;

  function automatic logic hdr_fits(input logic [POS_W-1:0] p);
    return p <= LAST_HDR;
  endfunction

endpackage

[hdl/ffha_if.sv]
interface ffha_req_if;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [ffha_pkg::REQ_W-1:0] req_size;
  logic [ffha_pkg::OFS_W-1:0] payload_offset;

  modport source(output valid, func, req_size, payload_offset, input ready);
  modport sink(input valid, func, req_size, payload_offset, output ready);
endinterface

interface ffha_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [2:0]                 status;
  logic [ffha_pkg::OFS_W-1:0] alloc_offset;

  modport source(output valid, status, alloc_offset, input ready);
  modport sink(input valid, status, alloc_offset, output ready);
endinterface

[hdl/ffha_ram.sv]
module ffha_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 14
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[hdl/ffha_ctrl.sv]
module ffha_ctrl (
  input  logic               clk,
  input  logic               rst,
  ffha_req_if.sink           req,
  ffha_rsp_if.source         rsp,
  output ffha_pkg::mem_req_t mem,
  input  ffha_pkg::entry_t   rdata
);

  ffha_pkg::state_t                 state, state_next;
  logic [ffha_pkg::ADDR_W-1:0]      clr_cnt, clr_cnt_next;
  logic [ffha_pkg::POS_W-1:0]       pos, pos_next;
  logic [ffha_pkg::POS_W-1:0]       ypos, ypos_next;
  logic [ffha_pkg::SIZE_W-1:0]      cur_size, cur_size_next;
  logic [ffha_pkg::REQ_W-1:0]       req_len, req_len_next;
  ffha_pkg::status_t                res_status, res_status_next;
  logic [ffha_pkg::OFS_W-1:0]       res_offset, res_offset_next;
  logic                             rsp_valid, rsp_valid_next;
  ffha_pkg::status_t                rsp_status, rsp_status_next;
  logic [ffha_pkg::OFS_W-1:0]       rsp_offset, rsp_offset_next;

  logic                             acc;
  logic                             too_big, zero_req, rel_low, rel_far;
  logic [ffha_pkg::OFS_W-1:0]       rel_h;
  logic                             d_none, d_free, d_used;
  logic                             fit_ok, split_ok;
  logic [ffha_pkg::SIZE_W-1:0]      surplus;
  logic [ffha_pkg::POS_W-1:0]       blk_end, split_pos, merged, merged_end;
  logic                             blk_end_fits, pos_fits, ypos_fits, rsp_free;

  assign req.ready = (state == ffha_pkg::ST_IDLE);
  assign acc       = req.valid && req.ready;

  assign too_big  = ({1'b0, req.req_size} + ffha_pkg::TWO_HDR_REQ) > ffha_pkg::HEAP_REQ;
  assign zero_req = (req.req_size == '0);
  assign rel_low  = (req.payload_offset < ffha_pkg::HDR_OFS);
  assign rel_h    = req.payload_offset - ffha_pkg::HDR_OFS;
  assign rel_far  = !ffha_pkg::hdr_fits(ffha_pkg::POS_W'(rel_h));

  assign d_none = (rdata.kind == ffha_pkg::KIND_NONE);
  assign d_free = (rdata.kind == ffha_pkg::KIND_FREE);
  assign d_used = (rdata.kind == ffha_pkg::KIND_USED);

  // req_len stays below the heap size once the too-big check passed
  assign fit_ok   = ({(ffha_pkg::REQ_W - ffha_pkg::SIZE_W)'(0), rdata.size} >= req_len);
  assign surplus  = rdata.size - req_len[ffha_pkg::SIZE_W-1:0];
  assign split_ok = (surplus >= ffha_pkg::HDR_SIZE);

  assign blk_end    = pos + ffha_pkg::HDR_POS + {1'b0, rdata.size};
  assign split_pos  = pos + ffha_pkg::HDR_POS + {1'b0, req_len[ffha_pkg::SIZE_W-1:0]};
  assign merged     = {1'b0, cur_size} + ffha_pkg::HDR_POS + {1'b0, rdata.size};
  assign merged_end = ypos + ffha_pkg::HDR_POS + {1'b0, rdata.size};

  assign blk_end_fits = ffha_pkg::hdr_fits(blk_end);
  assign pos_fits     = ffha_pkg::hdr_fits(pos);
  assign ypos_fits    = ffha_pkg::hdr_fits(ypos);
  assign rsp_free     = !rsp_valid || rsp.ready;

  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_status;
  assign rsp.alloc_offset = rsp_offset;

  always_comb begin
    state_next = state;
    unique case (state)
      ffha_pkg::ST_CLEAR: begin
        if (clr_cnt == '1) state_next = ffha_pkg::ST_IDLE;
      end
      ffha_pkg::ST_IDLE: begin
        if (acc) begin
          if (req.func == ffha_pkg::FUNC_RELEASE) begin
            state_next = (rel_low || rel_far) ? ffha_pkg::ST_DONE : ffha_pkg::ST_R_EV;
          end else begin
            state_next = (too_big || zero_req) ? ffha_pkg::ST_DONE : ffha_pkg::ST_A_EV;
          end
        end
      end
      ffha_pkg::ST_A_EV: begin
        priority if (d_none) begin
          state_next = (pos == '0) ? ffha_pkg::ST_A_SPLIT : ffha_pkg::ST_DONE;
        end else if (d_free && fit_ok) begin
          state_next = split_ok ? ffha_pkg::ST_A_SPLIT : ffha_pkg::ST_DONE;
        end else if (blk_end_fits) begin
          state_next = ffha_pkg::ST_A_EV;
        end else begin
          state_next = ffha_pkg::ST_DONE;
        end
      end
      ffha_pkg::ST_A_SPLIT: state_next = ffha_pkg::ST_DONE;
      ffha_pkg::ST_R_EV: begin
        state_next = (d_used && rdata.size != '0) ? ffha_pkg::ST_M_RD_X : ffha_pkg::ST_DONE;
      end
      ffha_pkg::ST_M_RD_X: begin
        state_next = pos_fits ? ffha_pkg::ST_M_EV_X : ffha_pkg::ST_DONE;
      end
      ffha_pkg::ST_M_EV_X: begin
        priority if (d_none || !blk_end_fits) begin
          state_next = ffha_pkg::ST_DONE;
        end else if (d_free) begin
          state_next = ffha_pkg::ST_M_EV_Y;
        end else begin
          state_next = ffha_pkg::ST_M_EV_X;
        end
      end
      ffha_pkg::ST_M_EV_Y: begin
        state_next = d_free ? ffha_pkg::ST_M_RD_Y : ffha_pkg::ST_M_WR_X;
      end
      ffha_pkg::ST_M_RD_Y: begin
        state_next = ypos_fits ? ffha_pkg::ST_M_EV_Y : ffha_pkg::ST_M_WR_X;
      end
      ffha_pkg::ST_M_WR_X: state_next = ffha_pkg::ST_M_RD_X;
      ffha_pkg::ST_DONE: begin
        if (rsp_free) state_next = ffha_pkg::ST_IDLE;
      end
      default: state_next = ffha_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mem             = '0;
    clr_cnt_next    = clr_cnt;
    pos_next        = pos;
    ypos_next       = ypos;
    cur_size_next   = cur_size;
    req_len_next    = req_len;
    res_status_next = res_status;
    res_offset_next = res_offset;
    rsp_valid_next  = rsp_valid && !rsp.ready;
    rsp_status_next = rsp_status;
    rsp_offset_next = rsp_offset;

    unique case (state)
      ffha_pkg::ST_CLEAR: begin
        mem.en       = 1'b1;
        mem.we       = 1'b1;
        mem.addr     = clr_cnt;
        mem.wdata    = '{kind: ffha_pkg::KIND_NONE, size: '0};
        clr_cnt_next = clr_cnt + 1'b1;
      end
      ffha_pkg::ST_IDLE: begin
        if (acc) begin
          req_len_next    = req.req_size;
          res_offset_next = '0;
          res_status_next = ffha_pkg::STAT_OK;
          if (req.func == ffha_pkg::FUNC_RELEASE) begin
            if (rel_low || rel_far) begin
              res_status_next = ffha_pkg::STAT_WRONG;
            end else begin
              mem.en   = 1'b1;
              mem.addr = ffha_pkg::ADDR_W'(rel_h);
              pos_next = ffha_pkg::POS_W'(rel_h);
            end
          end else begin
            priority if (too_big) begin
              res_status_next = ffha_pkg::STAT_TOO_BIG;
            end else if (zero_req) begin
              res_status_next = ffha_pkg::STAT_ZERO;
            end else begin
              mem.en   = 1'b1;
              mem.addr = '0;
              pos_next = '0;
            end
          end
        end
      end
      ffha_pkg::ST_A_EV: begin
        priority if (d_none) begin
          if (pos == '0) begin
            // empty heap: used block at zero, one free block behind it
            mem.en          = 1'b1;
            mem.we          = 1'b1;
            mem.addr        = '0;
            mem.wdata       = '{kind: ffha_pkg::KIND_USED,
                                size: req_len[ffha_pkg::SIZE_W-1:0]};
            ypos_next       = split_pos;
            cur_size_next   = ffha_pkg::FIRST_FREE - req_len[ffha_pkg::SIZE_W-1:0];
            res_status_next = ffha_pkg::STAT_OK;
            res_offset_next = ffha_pkg::HDR_OFS;
          end else begin
            res_status_next = ffha_pkg::STAT_NO_MEM;
          end
        end else if (d_free && fit_ok) begin
          mem.en          = 1'b1;
          mem.we          = 1'b1;
          mem.addr        = pos[ffha_pkg::ADDR_W-1:0];
          res_status_next = ffha_pkg::STAT_OK;
          res_offset_next = ffha_pkg::OFS_W'(pos + ffha_pkg::HDR_POS);
          if (split_ok) begin
            mem.wdata     = '{kind: ffha_pkg::KIND_USED,
                              size: req_len[ffha_pkg::SIZE_W-1:0]};
            ypos_next     = split_pos;
            cur_size_next = surplus - ffha_pkg::HDR_SIZE;
          end else begin
            mem.wdata     = '{kind: ffha_pkg::KIND_USED, size: rdata.size};
          end
        end else if (blk_end_fits) begin
          mem.en   = 1'b1;
          mem.addr = blk_end[ffha_pkg::ADDR_W-1:0];
          pos_next = blk_end;
        end else begin
          res_status_next = ffha_pkg::STAT_NO_MEM;
        end
      end
      ffha_pkg::ST_A_SPLIT: begin
        mem.en    = 1'b1;
        mem.we    = 1'b1;
        mem.addr  = ypos[ffha_pkg::ADDR_W-1:0];
        mem.wdata = '{kind: ffha_pkg::KIND_FREE, size: cur_size};
      end
      ffha_pkg::ST_R_EV: begin
        priority if (d_free) begin
          res_status_next = ffha_pkg::STAT_DOUBLE;
        end else if (d_used && rdata.size != '0) begin
          mem.en          = 1'b1;
          mem.we          = 1'b1;
          mem.addr        = pos[ffha_pkg::ADDR_W-1:0];
          mem.wdata       = '{kind: ffha_pkg::KIND_FREE, size: rdata.size};
          pos_next        = '0;
          res_status_next = ffha_pkg::STAT_OK;
        end else begin
          res_status_next = ffha_pkg::STAT_WRONG;
        end
      end
      ffha_pkg::ST_M_RD_X: begin
        if (pos_fits) begin
          mem.en   = 1'b1;
          mem.addr = pos[ffha_pkg::ADDR_W-1:0];
        end
      end
      ffha_pkg::ST_M_EV_X: begin
        if (!d_none && blk_end_fits) begin
          mem.en   = 1'b1;
          mem.addr = blk_end[ffha_pkg::ADDR_W-1:0];
          if (d_free) begin
            cur_size_next = rdata.size;
            ypos_next     = blk_end;
          end else begin
            pos_next      = blk_end;
          end
        end
      end
      ffha_pkg::ST_M_EV_Y: begin
        if (d_free) begin
          // absorb the neighbor and wipe its header
          mem.en        = 1'b1;
          mem.we        = 1'b1;
          mem.addr      = ypos[ffha_pkg::ADDR_W-1:0];
          mem.wdata     = '{kind: ffha_pkg::KIND_NONE, size: '0};
          cur_size_next = merged[ffha_pkg::SIZE_W-1:0];
          ypos_next     = merged_end;
        end
      end
      ffha_pkg::ST_M_RD_Y: begin
        if (ypos_fits) begin
          mem.en   = 1'b1;
          mem.addr = ypos[ffha_pkg::ADDR_W-1:0];
        end
      end
      ffha_pkg::ST_M_WR_X: begin
        mem.en    = 1'b1;
        mem.we    = 1'b1;
        mem.addr  = pos[ffha_pkg::ADDR_W-1:0];
        mem.wdata = '{kind: ffha_pkg::KIND_FREE, size: cur_size};
        pos_next  = pos + ffha_pkg::HDR_POS + {1'b0, cur_size};
      end
      ffha_pkg::ST_DONE: begin
        if (rsp_free) begin
          rsp_valid_next  = 1'b1;
          rsp_status_next = res_status;
          rsp_offset_next = res_offset;
        end
      end
      default: begin
        mem = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ffha_pkg::ST_CLEAR;
      clr_cnt   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_cnt   <= clr_cnt_next;
      rsp_valid <= rsp_valid_next;
    end
    pos        <= pos_next;
    ypos       <= ypos_next;
    cur_size   <= cur_size_next;
    req_len    <= req_len_next;
    res_status <= res_status_next;
    res_offset <= res_offset_next;
    rsp_status <= rsp_status_next;
    rsp_offset <= rsp_offset_next;
  end

endmodule

[hdl/first_fit_heap_allocator.sv]
// channel | dir | word
// --------+-----+-----------------------------------------------
// req     | in  | func, req_size[15:0], payload_offset[11:0]
// rsp     | out | status[2:0], alloc_offset[11:0]
//
// Header store is one 4096 x 14 single-port RAM, one access per cycle.
// After reset a clearing pass writes every entry, with req.ready low.
// Allocate: walks headers from zero; a split writes a free header for the rest.
// Release: frees the block, then walks from zero and merges each free block
// with the free blocks behind it; a malformed request skips the walk.
// One request at a time; rsp is registered, so req is taken while a word waits.
module first_fit_heap_allocator (
  input logic        clk,
  input logic        rst,
  ffha_req_if.sink   req,
  ffha_rsp_if.source rsp
);

  ffha_pkg::mem_req_t                   mem;
  ffha_pkg::entry_t                     rdata;
  logic [$bits(ffha_pkg::entry_t)-1:0]  ram_rdata;

  assign rdata = ffha_pkg::entry_t'(ram_rdata);

  ffha_ram #(
    .DEPTH(ffha_pkg::HEAP_BYTES),
    .WIDTH($bits(ffha_pkg::entry_t))
  ) u_ram (
    .clk  (clk),
    .en   (mem.en),
    .we   (mem.we),
    .addr (mem.addr),
    .wdata(mem.wdata),
    .rdata(ram_rdata)
  );

  ffha_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .mem  (mem),
    .rdata(rdata)
  );

endmodule
